// ===== design/mbd_pkg.sv =====
// shared types, codes and the instruction decode function for the block decoder
`default_nettype none
package mbd_pkg;

  localparam int unsigned MaxBlockLen = 4096;
  localparam int unsigned IdxW = 12;

  localparam logic [5:0] FlagBranch = 6'h01;
  localparam logic [5:0] FlagDirect = 6'h02;
  localparam logic [5:0] FlagLikely = 6'h04;
  localparam logic [5:0] FlagSigned = 6'h08;
  localparam logic [5:0] FlagImm    = 6'h10;
  localparam logic [5:0] FlagBad    = 6'h20;

  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpRegimm  = 6'h01;
  localparam logic [5:0] OpJ       = 6'h02;
  localparam logic [5:0] OpJal     = 6'h03;
  localparam logic [5:0] OpCop0    = 6'h10;
  localparam logic [5:0] OpCop1    = 6'h11;
  localparam logic [5:0] OpCop2    = 6'h12;
  localparam logic [5:0] OpMmi     = 6'h1c;

  localparam logic [5:0] FnDsll32 = 6'h3c;
  localparam logic [5:0] FnDsrl32 = 6'h3e;
  localparam logic [5:0] FnDsra32 = 6'h3f;

  typedef struct packed {
    logic [5:0] flags;
    logic [2:0] cond;
    logic [6:0] handler;
    logic [5:0] op_class;
  } dec_t;

  function automatic dec_t mk(input int c, input int h, input int cd, input logic [5:0] f);
    dec_t r;
    r.op_class = 6'(c);
    r.handler  = 7'(h);
    r.cond     = 3'(cd);
    r.flags    = f;
    return r;
  endfunction

  function automatic dec_t bad();
    return mk(0, 0, 0, FlagBad);
  endfunction

  function automatic dec_t dec_special(input logic [31:0] w);
    dec_t r;
    case (w[5:0])
      6'h00: r = mk((w == 32'd0) ? 0 : 6, 7, 0, 6'h00);
      6'h08: r = mk(7, 8, 0, FlagBranch);
      6'h0f: r = mk(0, 9, 0, 6'h00);
      6'h09: r = mk(8, 10, 0, FlagBranch);
      6'h03: r = mk(9, 11, 0, FlagImm);
      6'h21: r = mk(10, 12, 0, 6'h00);
      6'h2d: r = mk(11, 13, 0, 6'h00);
      6'h25: r = mk(12, 14, 0, 6'h00);
      6'h18: r = mk(13, 15, 0, FlagSigned);
      6'h1b: r = mk(14, 16, 0, 6'h00);
      6'h12: r = mk(15, 17, 0, 6'h00);
      6'h1a: r = mk(14, 18, 0, FlagSigned);
      6'h10: r = mk(16, 19, 0, 6'h00);
      6'h2b: r = mk(17, 20, 0, 6'h00);
      6'h23: r = mk(18, 21, 0, 6'h00);
      6'h0b: r = mk(19, 22, 2, 6'h00);
      6'h2a: r = mk(17, 23, 0, FlagSigned);
      6'h24: r = mk(20, 24, 0, 6'h00);
      6'h02: r = mk(21, 25, 0, FlagImm);
      6'h3c: r = mk(22, 26, 0, FlagImm);
      6'h3f: r = mk(23, 27, 0, FlagImm);
      6'h38: r = mk(22, 28, 0, FlagImm);
      6'h17: r = mk(23, 29, 0, 6'h00);
      6'h0a: r = mk(19, 30, 1, 6'h00);
      6'h14: r = mk(22, 31, 0, 6'h00);
      6'h04: r = mk(6, 32, 0, 6'h00);
      6'h07: r = mk(9, 33, 0, 6'h00);
      6'h27: r = mk(24, 34, 0, 6'h00);
      6'h3a: r = mk(25, 35, 0, FlagImm);
      6'h06: r = mk(21, 36, 0, 6'h00);
      6'h3e: r = mk(25, 37, 0, FlagImm);
      6'h0c: r = mk(26, 38, 0, FlagBranch | FlagDirect);
      6'h28: r = mk(27, 39, 0, 6'h00);
      6'h11: r = mk(28, 40, 0, 6'h00);
      6'h13: r = mk(29, 41, 0, 6'h00);
      6'h29: r = mk(30, 42, 0, 6'h00);
      6'h2f: r = mk(31, 43, 0, 6'h00);
      6'h26: r = mk(32, 44, 0, 6'h00);
      6'h19: r = mk(13, 45, 0, 6'h00);
      6'h3b: r = mk(23, 46, 0, FlagImm);
      6'h22: r = mk(18, 47, 0, FlagSigned);
      6'h20: r = mk(10, 48, 0, FlagSigned);
      6'h0d: r = mk(0, 0, 0, 6'h00);
      default: r = bad();
    endcase
    return r;
  endfunction

  function automatic dec_t dec_mmi(input logic [31:0] w);
    dec_t r;
    case (w[5:0])
      6'h20: r = mk(11, 49, 0, 6'h00);
      6'h00: r = mk(11, 50, 0, 6'h00);
      6'h1b: r = mk(14, 51, 0, 6'h00);
      6'h12: r = mk(15, 52, 0, 6'h00);
      6'h18: r = mk(33, 53, 0, 6'h00);
      6'h04: r = mk(33, 54, 0, 6'h00);
      6'h10: r = mk(33, 55, 0, 6'h00);
      6'h11: r = mk(33, 56, 0, 6'h00);
      6'h13: r = mk(33, 57, 0, 6'h00);
      6'h29: begin
        case (w[10:6])
          5'h12: r = mk(33, 58, 0, 6'h00);
          5'h1b: r = mk(33, 59, 0, 6'h00);
          5'h13: r = mk(33, 60, 0, 6'h00);
          5'h0e: r = mk(33, 61, 0, 6'h00);
          default: r = bad();
        endcase
      end
      6'h08: begin
        case (w[10:6])
          5'h09: r = mk(33, 62, 0, 6'h00);
          5'h01: r = mk(33, 63, 0, 6'h00);
          default: r = bad();
        endcase
      end
      6'h28: r = (w[10:6] == 5'h10) ? mk(33, 64, 0, 6'h00) : bad();
      default: r = bad();
    endcase
    return r;
  endfunction

  function automatic dec_t dec_cop0(input logic [31:0] w);
    dec_t r;
    case (w[25:21])
      5'h00: r = (w[2:0] == 3'd0) ? mk(1, 1, 0, 6'h00) : bad();
      5'h04: r = (w[2:0] == 3'd0) ? mk(2, 2, 0, 6'h00) : bad();
      5'h10: begin
        case (w[5:0])
          6'h02: r = mk(0, 3, 0, 6'h00);
          6'h39: r = mk(3, 4, 0, 6'h00);
          6'h18: r = mk(4, 5, 0, FlagBranch | FlagDirect);
          6'h38: r = mk(5, 6, 0, 6'h00);
          default: r = bad();
        endcase
      end
      default: r = bad();
    endcase
    return r;
  endfunction

  function automatic dec_t dec_regimm(input logic [31:0] w);
    dec_t r;
    case (w[20:16])
      5'h01: r = mk(35, 75, 3, FlagBranch);
      5'h00: r = mk(35, 76, 4, FlagBranch);
      5'h02: r = mk(39, 77, 4, FlagBranch | FlagLikely);
      5'h03: r = mk(39, 78, 3, FlagBranch | FlagLikely);
      default: r = bad();
    endcase
    return r;
  endfunction

  function automatic dec_t dec_word(input logic [31:0] w);
    dec_t r;
    case (w[31:26])
      OpSpecial: r = dec_special(w);
      OpCop0:    r = dec_cop0(w);
      OpCop1:    r = mk(0, 0, 0, 6'h00);
      OpCop2:    r = (w[25:21] inside {5'd1, 5'd2, 5'd5, 5'd6, [5'd16:5'd31]})
                     ? mk(0, 0, 0, 6'h00) : bad();
      OpMmi:     r = dec_mmi(w);
      OpRegimm:  r = dec_regimm(w);
      6'h2b: r = mk(34, 65, 0, 6'h00);
      6'h0a: r = mk(17, 66, 0, FlagImm | FlagSigned);
      6'h05: r = mk(35, 67, 2, FlagBranch);
      6'h0d: r = mk(12, 68, 0, FlagImm);
      6'h08: r = mk(10, 69, 0, FlagImm | FlagSigned);
      6'h1e: r = mk(36, 70, 0, 6'h00);
      6'h0f: r = mk(37, 71, 0, 6'h00);
      6'h09: r = mk(10, 72, 0, FlagImm);
      6'h3f: r = mk(38, 73, 0, 6'h00);
      OpJal: r = mk(8, 74, 0, FlagImm | FlagBranch);
      6'h0c: r = mk(20, 79, 0, FlagImm);
      6'h04: r = mk(35, 80, 1, FlagBranch);
      6'h14: r = mk(39, 81, 1, FlagBranch | FlagLikely);
      6'h0b: r = mk(17, 82, 0, FlagImm);
      6'h15: r = mk(39, 83, 2, FlagBranch | FlagLikely);
      6'h20: r = mk(40, 84, 0, FlagSigned);
      6'h39: r = mk(41, 85, 0, 6'h00);
      6'h24: r = mk(40, 86, 0, 6'h00);
      6'h37: r = mk(42, 87, 0, 6'h00);
      OpJ:   r = mk(7, 88, 0, FlagImm | FlagBranch);
      6'h23: r = mk(43, 89, 0, FlagSigned);
      6'h28: r = mk(44, 90, 0, 6'h00);
      6'h06: r = mk(35, 91, 5, FlagBranch);
      6'h07: r = mk(35, 92, 6, FlagBranch);
      6'h25: r = mk(45, 93, 0, 6'h00);
      6'h29: r = mk(46, 94, 0, 6'h00);
      6'h0e: r = mk(32, 95, 0, FlagImm);
      6'h19: r = mk(11, 96, 0, FlagImm);
      6'h1f: r = mk(47, 97, 0, 6'h00);
      6'h21: r = mk(45, 98, 0, FlagSigned);
      6'h2f: r = mk(0, 99, 0, 6'h00);
      6'h27: r = mk(43, 100, 0, 6'h00);
      6'h1a: r = mk(48, 101, 0, 6'h00);
      6'h1b: r = mk(49, 102, 0, 6'h00);
      6'h2c: r = mk(50, 103, 0, 6'h00);
      6'h2d: r = mk(51, 104, 0, 6'h00);
      6'h31: r = mk(52, 105, 0, 6'h00);
      6'h16: r = mk(39, 106, 5, FlagBranch | FlagLikely);
      6'h22: r = mk(53, 107, 0, 6'h00);
      6'h26: r = mk(54, 108, 0, 6'h00);
      6'h2a: r = mk(55, 109, 0, 6'h00);
      6'h2e: r = mk(56, 110, 0, 6'h00);
      default: r = bad();
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/mips_block_decoder.sv =====
// top level: instruction decode with translation block tracking
//
// slave channel s_axis: one beat per instruction word with the block start
// address beside it; the address is used only on the first beat of a block.
// master channel m_axis: one beat per instruction with the decoded fields;
// m_axis_tlast marks the last instruction of the translation block.
// an accepted input beat passes through the input register, then the decode
// table and block update into the output buffer. one beat can be taken every
// cycle while s_axis_tready is high.
// the output buffer holds two beats; s_axis_tready is high while the input
// register and the buffer, less the beat leaving this cycle, hold at most one
// beat, so it follows m_axis_tready in the same cycle. a stalled receiver
// fills the buffer and then stops the input; no beat is lost or repeated.
// reset empties both registers and closes the block, so the next beat opens
// a new block at its start address.
`default_nettype none
module mips_block_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // instr_word, block_pc
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // instr_pc, op_class, handler_id, branch_cond, flag_bits, dest_reg, src_reg,
  // tgt_reg, shift_amount, imm_value, cycles_before (zero padded to 120 bits)
  output logic [119:0]     m_axis_tdata,
  output logic             m_axis_tlast
);

  logic        in_vld_q;
  logic [31:0] word_q;
  logic [31:0] bpc_q;
  logic        open_q;
  logic [31:0] start_q;
  logic [mbd_pkg::IdxW-1:0] idx_q;
  logic        lastbr_q;

  logic [1:0]   cnt_q;
  logic [112:0] dat_q [2];
  logic         lst_q [2];
  logic         rd_q;

  mbd_pkg::dec_t dec;
  logic [31:0] start_d;
  logic [mbd_pkg::IdxW-1:0] idx_use;
  logic        lastbr_use;
  logic [5:0]  shift;
  logic [25:0] imm;
  logic        fin;
  logic [112:0] res;
  logic        push, pop;
  logic [1:0]  occ;

  // beats held after this cycle's output beat leaves
  assign occ = cnt_q + {1'b0, in_vld_q} - {1'b0, pop};
  assign s_axis_tready = (occ <= 2'd1);
  assign push = in_vld_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    dec        = mbd_pkg::dec_word(word_q);
    start_d    = open_q ? start_q : bpc_q;
    idx_use    = open_q ? idx_q : '0;
    lastbr_use = open_q ? lastbr_q : 1'b0;
    shift      = {1'b0, word_q[10:6]};
    if (word_q[31:26] == mbd_pkg::OpSpecial &&
        (word_q[5:0] == mbd_pkg::FnDsll32 || word_q[5:0] == mbd_pkg::FnDsrl32 ||
         word_q[5:0] == mbd_pkg::FnDsra32)) begin
      shift = shift + 6'd32;
    end
    imm = (word_q[31:26] == mbd_pkg::OpJ || word_q[31:26] == mbd_pkg::OpJal)
          ? word_q[25:0] : {10'd0, word_q[15:0]};
    fin = ((dec.flags & mbd_pkg::FlagBad) != 6'd0)
       || (idx_use != '0 && (lastbr_use || (dec.flags & mbd_pkg::FlagDirect) != 6'd0))
       || (idx_use == mbd_pkg::IdxW'(mbd_pkg::MaxBlockLen - 1));
    res = {idx_use, imm, shift, word_q[20:16], word_q[25:21], word_q[15:11],
           dec.flags, dec.cond, dec.handler, dec.op_class,
           start_d + {18'd0, idx_use, 2'b00}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      open_q   <= 1'b0;
      idx_q    <= '0;
      lastbr_q <= 1'b0;
      start_q  <= '0;
      cnt_q    <= 2'd0;
      rd_q     <= 1'b0;
    end else begin
      in_vld_q <= s_axis_tvalid && s_axis_tready;
      if (push) begin
        start_q <= start_d;
        if (fin) begin
          open_q   <= 1'b0;
          idx_q    <= '0;
          lastbr_q <= 1'b0;
        end else begin
          open_q   <= 1'b1;
          idx_q    <= idx_use + mbd_pkg::IdxW'(1);
          lastbr_q <= (dec.flags & mbd_pkg::FlagBranch) != 6'd0;
        end
      end
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      word_q <= s_axis_tdata[31:0];
      bpc_q  <= s_axis_tdata[63:32];
    end
    if (push) begin
      dat_q[rd_q ^ cnt_q[0]] <= res;
      lst_q[rd_q ^ cnt_q[0]] <= fin;
    end
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {7'd0, dat_q[rd_q]};
  assign m_axis_tlast  = lst_q[rd_q];

endmodule
`default_nettype wire

// ===== design/mbd_checker.sv =====
// port-level checks for the block decoder, bound to the top level
`default_nettype none
module mbd_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [119:0] m_axis_tdata,
  input wire logic         m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped while stalled");

  a_bad_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[53] |-> m_axis_tlast)
    else $error("undecodable word did not end block");

  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[53] |-> m_axis_tdata[50:32] == 19'd0)
    else $error("undecodable word carries decode");

  a_first_tlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[112:101] == 12'd0 && !m_axis_tdata[53]
      |-> !m_axis_tlast)
    else $error("block ended on its first word");

  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("no output beat after input");

endmodule

bind mips_block_decoder mbd_checker u_mbd_checker (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the block decoder: directed and random stimulus
module testbench;

  typedef struct packed {
    logic [5:0] flg;
    logic [2:0] cnd;
    logic [6:0] hdl;
    logic [5:0] cls;
  } dec_exp_t;

  typedef struct {
    logic [31:0] pc;
    logic [5:0]  cls;
    logic [6:0]  hdl;
    logic [2:0]  cnd;
    logic [5:0]  flg;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [5:0]  sa;
    logic [25:0] imm;
    logic [11:0] cyc;
    logic        last;
  } decoded_t;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // instr_word, block_pc
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // instr_pc, op_class, handler_id, branch_cond, flag_bits, dest_reg, src_reg,
  // tgt_reg, shift_amount, imm_value, cycles_before
  logic [119:0] m_axis_tdata;
  logic m_axis_tlast;

  decoded_t    pending_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          busy_mode = 1'b0;

  logic [31:0] blk_start = '0;
  int unsigned blk_idx = 0;
  bit          blk_prev_branch = 1'b0;
  bit          blk_open = 1'b0;

  mips_block_decoder u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= busy_mode || ($urandom_range(99) >= 25);
  end

  function automatic dec_exp_t ent(int c, int h, int cd, logic [5:0] f);
    dec_exp_t e;
    e.cls = 6'(c);
    e.hdl = 7'(h);
    e.cnd = 3'(cd);
    e.flg = f;
    return e;
  endfunction

  function automatic dec_exp_t undecodable();
    return ent(0, 0, 0, mbd_pkg::FlagBad);
  endfunction

  function automatic dec_exp_t decode_word(logic [31:0] w);
    logic [4:0] sa;
    logic [4:0] rs;
    dec_exp_t e;
    sa = w[10:6];
    rs = w[25:21];
    e = undecodable();
    case (w[31:26])
      mbd_pkg::OpSpecial:
        case (w[5:0])
          6'h00: e = ent(w == 0 ? 0 : 6, 7, 0, 0);
          6'h08: e = ent(7, 8, 0, mbd_pkg::FlagBranch);
          6'h0f: e = ent(0, 9, 0, 0);
          6'h09: e = ent(8, 10, 0, mbd_pkg::FlagBranch);
          6'h03: e = ent(9, 11, 0, mbd_pkg::FlagImm);
          6'h21: e = ent(10, 12, 0, 0);
          6'h2d: e = ent(11, 13, 0, 0);
          6'h25: e = ent(12, 14, 0, 0);
          6'h18: e = ent(13, 15, 0, mbd_pkg::FlagSigned);
          6'h1b: e = ent(14, 16, 0, 0);
          6'h12: e = ent(15, 17, 0, 0);
          6'h1a: e = ent(14, 18, 0, mbd_pkg::FlagSigned);
          6'h10: e = ent(16, 19, 0, 0);
          6'h2b: e = ent(17, 20, 0, 0);
          6'h23: e = ent(18, 21, 0, 0);
          6'h0b: e = ent(19, 22, 2, 0);
          6'h2a: e = ent(17, 23, 0, mbd_pkg::FlagSigned);
          6'h24: e = ent(20, 24, 0, 0);
          6'h02: e = ent(21, 25, 0, mbd_pkg::FlagImm);
          mbd_pkg::FnDsll32: e = ent(22, 26, 0, mbd_pkg::FlagImm);
          mbd_pkg::FnDsra32: e = ent(23, 27, 0, mbd_pkg::FlagImm);
          6'h38: e = ent(22, 28, 0, mbd_pkg::FlagImm);
          6'h17: e = ent(23, 29, 0, 0);
          6'h0a: e = ent(19, 30, 1, 0);
          6'h14: e = ent(22, 31, 0, 0);
          6'h04: e = ent(6, 32, 0, 0);
          6'h07: e = ent(9, 33, 0, 0);
          6'h27: e = ent(24, 34, 0, 0);
          6'h3a: e = ent(25, 35, 0, mbd_pkg::FlagImm);
          6'h06: e = ent(21, 36, 0, 0);
          mbd_pkg::FnDsrl32: e = ent(25, 37, 0, mbd_pkg::FlagImm);
          6'h0c: e = ent(26, 38, 0, mbd_pkg::FlagBranch | mbd_pkg::FlagDirect);
          6'h28: e = ent(27, 39, 0, 0);
          6'h11: e = ent(28, 40, 0, 0);
          6'h13: e = ent(29, 41, 0, 0);
          6'h29: e = ent(30, 42, 0, 0);
          6'h2f: e = ent(31, 43, 0, 0);
          6'h26: e = ent(32, 44, 0, 0);
          6'h19: e = ent(13, 45, 0, 0);
          6'h3b: e = ent(23, 46, 0, mbd_pkg::FlagImm);
          6'h22: e = ent(18, 47, 0, mbd_pkg::FlagSigned);
          6'h20: e = ent(10, 48, 0, mbd_pkg::FlagSigned);
          6'h0d: e = ent(0, 0, 0, 0);
          default: e = undecodable();
        endcase
      mbd_pkg::OpCop0:
        case (rs)
          5'h00: if (w[2:0] == 0) e = ent(1, 1, 0, 0);
          5'h04: if (w[2:0] == 0) e = ent(2, 2, 0, 0);
          5'h10:
            case (w[5:0])
              6'h02: e = ent(0, 3, 0, 0);
              6'h39: e = ent(3, 4, 0, 0);
              6'h18: e = ent(4, 5, 0, mbd_pkg::FlagBranch | mbd_pkg::FlagDirect);
              6'h38: e = ent(5, 6, 0, 0);
              default: e = undecodable();
            endcase
          default: e = undecodable();
        endcase
      mbd_pkg::OpCop1: e = ent(0, 0, 0, 0);
      mbd_pkg::OpCop2:
        if (rs == 1 || rs == 2 || rs == 5 || rs == 6 || rs >= 16) e = ent(0, 0, 0, 0);
      mbd_pkg::OpMmi:
        case (w[5:0])
          6'h20: e = ent(11, 49, 0, 0);
          6'h00: e = ent(11, 50, 0, 0);
          6'h1b: e = ent(14, 51, 0, 0);
          6'h12: e = ent(15, 52, 0, 0);
          6'h18: e = ent(33, 53, 0, 0);
          6'h04: e = ent(33, 54, 0, 0);
          6'h10: e = ent(33, 55, 0, 0);
          6'h11: e = ent(33, 56, 0, 0);
          6'h13: e = ent(33, 57, 0, 0);
          6'h29:
            case (sa)
              5'h12: e = ent(33, 58, 0, 0);
              5'h1b: e = ent(33, 59, 0, 0);
              5'h13: e = ent(33, 60, 0, 0);
              5'h0e: e = ent(33, 61, 0, 0);
              default: e = undecodable();
            endcase
          6'h08:
            case (sa)
              5'h09: e = ent(33, 62, 0, 0);
              5'h01: e = ent(33, 63, 0, 0);
              default: e = undecodable();
            endcase
          6'h28: if (sa == 5'h10) e = ent(33, 64, 0, 0);
          default: e = undecodable();
        endcase
      mbd_pkg::OpRegimm:
        case (w[20:16])
          5'h01: e = ent(35, 75, 3, mbd_pkg::FlagBranch);
          5'h00: e = ent(35, 76, 4, mbd_pkg::FlagBranch);
          5'h02: e = ent(39, 77, 4, mbd_pkg::FlagBranch | mbd_pkg::FlagLikely);
          5'h03: e = ent(39, 78, 3, mbd_pkg::FlagBranch | mbd_pkg::FlagLikely);
          default: e = undecodable();
        endcase
      6'h2b: e = ent(34, 65, 0, 0);
      6'h0a: e = ent(17, 66, 0, mbd_pkg::FlagImm | mbd_pkg::FlagSigned);
      6'h05: e = ent(35, 67, 2, mbd_pkg::FlagBranch);
      6'h0d: e = ent(12, 68, 0, mbd_pkg::FlagImm);
      6'h08: e = ent(10, 69, 0, mbd_pkg::FlagImm | mbd_pkg::FlagSigned);
      6'h1e: e = ent(36, 70, 0, 0);
      6'h0f: e = ent(37, 71, 0, 0);
      6'h09: e = ent(10, 72, 0, mbd_pkg::FlagImm);
      6'h3f: e = ent(38, 73, 0, 0);
      mbd_pkg::OpJal: e = ent(8, 74, 0, mbd_pkg::FlagImm | mbd_pkg::FlagBranch);
      6'h0c: e = ent(20, 79, 0, mbd_pkg::FlagImm);
      6'h04: e = ent(35, 80, 1, mbd_pkg::FlagBranch);
      6'h14: e = ent(39, 81, 1, mbd_pkg::FlagBranch | mbd_pkg::FlagLikely);
      6'h0b: e = ent(17, 82, 0, mbd_pkg::FlagImm);
      6'h15: e = ent(39, 83, 2, mbd_pkg::FlagBranch | mbd_pkg::FlagLikely);
      6'h20: e = ent(40, 84, 0, mbd_pkg::FlagSigned);
      6'h39: e = ent(41, 85, 0, 0);
      6'h24: e = ent(40, 86, 0, 0);
      6'h37: e = ent(42, 87, 0, 0);
      mbd_pkg::OpJ:   e = ent(7, 88, 0, mbd_pkg::FlagImm | mbd_pkg::FlagBranch);
      6'h23: e = ent(43, 89, 0, mbd_pkg::FlagSigned);
      6'h28: e = ent(44, 90, 0, 0);
      6'h06: e = ent(35, 91, 5, mbd_pkg::FlagBranch);
      6'h07: e = ent(35, 92, 6, mbd_pkg::FlagBranch);
      6'h25: e = ent(45, 93, 0, 0);
      6'h29: e = ent(46, 94, 0, 0);
      6'h0e: e = ent(32, 95, 0, mbd_pkg::FlagImm);
      6'h19: e = ent(11, 96, 0, mbd_pkg::FlagImm);
      6'h1f: e = ent(47, 97, 0, 0);
      6'h21: e = ent(45, 98, 0, mbd_pkg::FlagSigned);
      6'h2f: e = ent(0, 99, 0, 0);
      6'h27: e = ent(43, 100, 0, 0);
      6'h1a: e = ent(48, 101, 0, 0);
      6'h1b: e = ent(49, 102, 0, 0);
      6'h2c: e = ent(50, 103, 0, 0);
      6'h2d: e = ent(51, 104, 0, 0);
      6'h31: e = ent(52, 105, 0, 0);
      6'h16: e = ent(39, 106, 5, mbd_pkg::FlagBranch | mbd_pkg::FlagLikely);
      6'h22: e = ent(53, 107, 0, 0);
      6'h26: e = ent(54, 108, 0, 0);
      6'h2a: e = ent(55, 109, 0, 0);
      6'h2e: e = ent(56, 110, 0, 0);
      default: e = undecodable();
    endcase
    return e;
  endfunction

  // advances the block tracker and returns the expected output beat
  function automatic decoded_t track_block(logic [31:0] w, logic [31:0] bpc);
    decoded_t r;
    dec_exp_t e;
    bit fin;
    if (!blk_open) begin
      blk_start = bpc;
      blk_idx = 0;
      blk_prev_branch = 1'b0;
      blk_open = 1'b1;
    end
    e = decode_word(w);
    r.pc  = blk_start + 32'(4 * blk_idx);
    r.cls = e.cls;
    r.hdl = e.hdl;
    r.cnd = e.cnd;
    r.flg = e.flg;
    r.rd  = w[15:11];
    r.rs  = w[25:21];
    r.rt  = w[20:16];
    r.sa  = {1'b0, w[10:6]};
    if (w[31:26] == mbd_pkg::OpSpecial &&
        (w[5:0] == mbd_pkg::FnDsll32 || w[5:0] == mbd_pkg::FnDsrl32 ||
         w[5:0] == mbd_pkg::FnDsra32))
      r.sa = r.sa + 6'd32;
    r.imm = (w[31:26] == mbd_pkg::OpJ || w[31:26] == mbd_pkg::OpJal)
            ? w[25:0] : {10'd0, w[15:0]};
    r.cyc = blk_idx > 4095 ? 12'd4095 : 12'(blk_idx);
    fin = (e.flg & mbd_pkg::FlagBad) != 0 ||
          (blk_idx >= 1 && (blk_prev_branch || (e.flg & mbd_pkg::FlagDirect) != 0)) ||
          blk_idx + 1 >= mbd_pkg::MaxBlockLen;
    r.last = fin;
    if (fin) begin
      blk_open = 1'b0;
      blk_idx = 0;
      blk_prev_branch = 1'b0;
    end else begin
      blk_idx++;
      blk_prev_branch = (e.flg & mbd_pkg::FlagBranch) != 0;
    end
    return r;
  endfunction

  task automatic send_word(logic [31:0] w, logic [31:0] bpc);
    while (!busy_mode && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {bpc, w};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.insert(pending_q.size(), track_block(w, bpc));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    decoded_t x;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected beat %h", m_axis_tdata);
        errors++;
      end else begin
        x = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== x.pc) begin
          $error("instr_pc exp %h got %h", x.pc, m_axis_tdata[31:0]); errors++;
        end
        if (m_axis_tdata[37:32] !== x.cls) begin
          $error("op_class exp %0d got %0d", x.cls, m_axis_tdata[37:32]); errors++;
        end
        if (m_axis_tdata[44:38] !== x.hdl) begin
          $error("handler_id exp %0d got %0d", x.hdl, m_axis_tdata[44:38]); errors++;
        end
        if (m_axis_tdata[47:45] !== x.cnd) begin
          $error("branch_cond exp %0d got %0d", x.cnd, m_axis_tdata[47:45]); errors++;
        end
        if (m_axis_tdata[53:48] !== x.flg) begin
          $error("flag_bits exp %h got %h", x.flg, m_axis_tdata[53:48]); errors++;
        end
        if (m_axis_tdata[58:54] !== x.rd) begin
          $error("dest_reg exp %0d got %0d", x.rd, m_axis_tdata[58:54]); errors++;
        end
        if (m_axis_tdata[63:59] !== x.rs) begin
          $error("src_reg exp %0d got %0d", x.rs, m_axis_tdata[63:59]); errors++;
        end
        if (m_axis_tdata[68:64] !== x.rt) begin
          $error("tgt_reg exp %0d got %0d", x.rt, m_axis_tdata[68:64]); errors++;
        end
        if (m_axis_tdata[74:69] !== x.sa) begin
          $error("shift_amount exp %0d got %0d", x.sa, m_axis_tdata[74:69]); errors++;
        end
        if (m_axis_tdata[100:75] !== x.imm) begin
          $error("imm_value exp %h got %h", x.imm, m_axis_tdata[100:75]); errors++;
        end
        if (m_axis_tdata[112:101] !== x.cyc) begin
          $error("cycles_before exp %0d got %0d", x.cyc, m_axis_tdata[112:101]); errors++;
        end
        if (m_axis_tlast !== x.last) begin
          $error("block_end exp %0d got %0d", x.last, m_axis_tlast); errors++;
        end
      end
    end
  end

  // mostly decodable words with random operand fields
  function automatic logic [31:0] pick_word();
    logic [5:0] prim[] = '{6'h00, 6'h00, 6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h06,
      6'h07, 6'h08, 6'h09, 6'h0a, 6'h0b, 6'h0c, 6'h0d, 6'h0e, 6'h0f, 6'h10, 6'h11,
      6'h12, 6'h14, 6'h15, 6'h16, 6'h19, 6'h1a, 6'h1b, 6'h1c, 6'h1c, 6'h1e, 6'h1f,
      6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27, 6'h28, 6'h29, 6'h2a,
      6'h2b, 6'h2c, 6'h2d, 6'h2e, 6'h2f, 6'h31, 6'h37, 6'h39, 6'h3f};
    logic [5:0] spec[] = '{6'h00, 6'h02, 6'h03, 6'h04, 6'h06, 6'h07, 6'h08, 6'h09, 6'h0a,
      6'h0b, 6'h0c, 6'h0d, 6'h0f, 6'h10, 6'h11, 6'h12, 6'h13, 6'h14, 6'h17, 6'h18,
      6'h19, 6'h1a, 6'h1b, 6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27,
      6'h28, 6'h29, 6'h2a, 6'h2b, 6'h2d, 6'h2f, 6'h38, 6'h3a, 6'h3b, 6'h3c, 6'h3e, 6'h3f};
    logic [5:0] mmi[] = '{6'h20, 6'h00, 6'h1b, 6'h12, 6'h18, 6'h04, 6'h10, 6'h11,
      6'h13, 6'h29, 6'h08, 6'h28};
    logic [4:0] mmisa[] = '{5'h12, 5'h1b, 5'h13, 5'h0e, 5'h09, 5'h01, 5'h10};
    logic [5:0] c0fn[] = '{6'h02, 6'h39, 6'h18, 6'h38};
    logic [4:0] c0rs[] = '{5'h00, 5'h04, 5'h10};
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(99) < 80) begin
      w[31:26] = prim[$urandom_range(prim.size() - 1)];
      case (w[31:26])
        mbd_pkg::OpSpecial: w[5:0] = spec[$urandom_range(spec.size() - 1)];
        mbd_pkg::OpMmi: begin
          w[5:0] = mmi[$urandom_range(mmi.size() - 1)];
          if ($urandom_range(3) != 0) w[10:6] = mmisa[$urandom_range(mmisa.size() - 1)];
        end
        mbd_pkg::OpCop0: begin
          w[25:21] = c0rs[$urandom_range(c0rs.size() - 1)];
          if ($urandom_range(3) != 0) w[2:0] = 3'd0;
          if ($urandom_range(1) != 0) w[5:0] = c0fn[$urandom_range(c0fn.size() - 1)];
        end
        mbd_pkg::OpRegimm: if ($urandom_range(3) != 0) w[20:16] = 5'($urandom_range(3));
        default: ;
      endcase
    end
    return w;
  endfunction

  task automatic test_directed();
    send_word(32'h0000_0000, 32'hffff_fffc);
    send_word(32'h0000_0021, 32'hffff_ffff);
    send_word(32'hffff_ffff, 32'h0000_0000);
    send_word(32'h0000_000d, 32'h0000_0000);
    send_word(32'h0000_000c, 32'h1234_5678);
    send_word(32'h03e0_0008, 32'h8000_0000);
    send_word(32'h001f_ffc0 | mbd_pkg::FnDsll32, 32'h0);
    send_word(32'h001f_ffc0 | mbd_pkg::FnDsra32, 32'h0);
    send_word(32'h001f_ffc0 | mbd_pkg::FnDsrl32, 32'h0);
    send_word({mbd_pkg::OpJ, 26'h3ff_ffff}, 32'h0);
    send_word({mbd_pkg::OpJal, 26'h000_0000}, 32'hffff_ffff);
    send_word({mbd_pkg::OpCop1, 26'h3ff_ffff}, 32'h0);
    send_word({mbd_pkg::OpCop2, 5'd1, 21'h1f_ffff}, 32'h0);
    send_word({mbd_pkg::OpCop2, 5'd3, 21'h0}, 32'h4);
    send_word({mbd_pkg::OpMmi, 15'h7fff, 5'h12, 6'h29}, 32'h0);
    send_word({mbd_pkg::OpMmi, 15'h0, 5'h10, 6'h28}, 32'h0);
    send_word({mbd_pkg::OpMmi, 15'h0, 5'h11, 6'h28}, 32'h0);
    send_word({mbd_pkg::OpCop0, 5'h00, 21'h0_0000}, 32'h0);
    send_word({mbd_pkg::OpCop0, 5'h04, 21'h0_0001}, 32'h0);
    send_word({mbd_pkg::OpCop0, 5'h10, 21'h0_0018}, 32'h0);
    send_word({mbd_pkg::OpRegimm, 5'h1f, 5'h03, 16'hffff}, 32'h0);
    send_word(32'h0000_0021, 32'h0);
    send_word({mbd_pkg::OpRegimm, 5'h00, 5'h04, 16'h0}, 32'h0);
    drain();
  endtask

  task automatic test_random();
    int i;
    for (i = 0; i < 700; i++) begin
      busy_mode = (i >= 300 && i < 400);
      send_word(pick_word(), $urandom);
      if (i % 150 == 149) drain();
    end
    busy_mode = 1'b0;
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
